FILE: sv/mlm_pkg.sv
// mlm_pkg: shared types, codes and default sizes for the mutex lock manager.
// No dependencies; imported by every module of the block.
`default_nettype none

package mlm_pkg;

  // default sizes, overridable at the top level
  localparam int NUM_LOCKS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  // fixed field widths
  localparam int ID_W   = 16;
  localparam int TASK_W = 8;

  // request modes
  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  typedef enum logic [2:0] {
    OC_GRANTED  = 3'd0,
    OC_BLOCKED  = 3'd1,
    OC_QFULL    = 3'd2,
    OC_TFULL    = 3'd3,
    OC_FREED    = 3'd4,
    OC_HANDED   = 3'd5,
    OC_NOTOWNER = 3'd6
  } outcome_t;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   lock_id;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    outcome_t          outcome;
    logic              must_block;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/mutex_lock_manager_top.sv
// mutex_lock_manager_top: stream ports and output register of the lock manager.
// Depends on mlm_pkg and mlm_core.
//
//   channel  dir  payload                                        handshake
//   s_       in   tdata: lock_id[15:0] task_id[23:16]; tuser mode  s_tvalid/s_tready
//   m_       out  tdata: outcome, must_block, wake_valid, wake_task m_tvalid/m_tready
//
// A request goes through the id search, which reads one table entry per cycle
// through a single comparator, then an update step, plus a handover step that
// reads the oldest waiter from the slot memory.
// Reset is synchronous and empties the table at once; no clearing pass.
// A result waits in the output register while the next request is taken;
// s_tready drops while a request is in flight or its result cannot be stored.
`default_nettype none

module mutex_lock_manager_top import mlm_pkg::*; #(
  parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // lock_id[15:0], task_id[23:16]
  input  wire logic        s_tuser,  // mode: 0 lock, 1 unlock
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata   // outcome[2:0], must_block[3], wake_valid[4],
                                     // wake_task[12:5], zero[15:13]
);

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;

  assign req = '{mode: s_tuser, lock_id: s_tdata[15:0], task_id: s_tdata[23:16]};

  // output register accepts a result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {3'b000, res.wake_task, res.wake_valid, res.must_block, res.outcome};
    end
  end

  mlm_core #(
    .NUM_LOCKS   (NUM_LOCKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: sv/mlm_wait_mem.sv
// mlm_wait_mem: wait-slot memory, one write port and one registered read port.
// Depends on mlm_pkg for the task width.
`default_nettype none

module mlm_wait_mem import mlm_pkg::*; #(
  parameter int DEPTH = NUM_LOCKS_DEF * QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [TASK_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [TASK_W-1:0] rdata
);

  logic [TASK_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/mlm_core.sv
// mlm_core: sequencer, entry table and shared id comparator of the lock manager.
// Depends on mlm_pkg and mlm_wait_mem.
`default_nettype none

module mlm_core import mlm_pkg::*; #(
  parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  localparam int IW    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int UW    = $clog2(NUM_LOCKS + 1);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_LOCKS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_OP   = 5'b00100,
    S_HAND = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t            state;
  req_t              cur_req;
  logic [UW-1:0]     used;
  logic [UW-1:0]     scan_idx;
  logic              cmp_pend;
  logic [IW-1:0]     cmp_idx;
  logic [IW-1:0]     k;
  logic              cur_owned;
  logic [TASK_W-1:0] cur_owner;
  logic [CW-1:0]     cur_count;
  logic [QW-1:0]     cur_head;
  res_t              result;

  // entry table memory
  logic [ID_W-1:0]   ent_id    [NUM_LOCKS];
  logic              ent_owned [NUM_LOCKS];
  logic [TASK_W-1:0] ent_owner [NUM_LOCKS];
  logic [CW-1:0]     ent_count [NUM_LOCKS];
  logic [QW-1:0]     ent_head  [NUM_LOCKS];

  logic [IW-1:0]     ent_raddr;
  logic [ID_W-1:0]   rd_id;
  logic              rd_owned;
  logic [TASK_W-1:0] rd_owner;
  logic [CW-1:0]     rd_count;
  logic [QW-1:0]     rd_head;

  logic              ent_we;
  logic              w_owned;
  logic [TASK_W-1:0] w_owner;
  logic [CW-1:0]     w_count;
  logic [QW-1:0]     w_head;

  logic              wq_we;
  logic [AW-1:0]     wq_waddr;
  logic [AW-1:0]     wq_raddr;
  logic [TASK_W-1:0] wq_rdata;

  logic              hit;
  logic [CW:0]       tail_sum;
  logic [QW-1:0]     tail;
  logic [QW-1:0]     head_inc;
  logic              op_hand;
  res_t              op_res;

  function automatic logic [AW-1:0] slot_addr(input logic [IW-1:0] idx,
                                              input logic [QW-1:0] slot);
    slot_addr = AW'(32'(idx) * 32'(QUEUE_DEPTH) + 32'(slot));
  endfunction

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res       = result;

  // shared comparator and queue pointer arithmetic
  always_comb begin
    ent_raddr = scan_idx[IW-1:0];
    hit       = cmp_pend && (rd_id == cur_req.lock_id);
    tail_sum  = (CW+1)'(cur_head) + (CW+1)'(cur_count);
    if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
      tail = QW'(tail_sum - (CW+1)'(QUEUE_DEPTH));
    end else begin
      tail = QW'(tail_sum);
    end
    if (cur_head == QW'(QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = cur_head + QW'(1);
    end
    wq_waddr = slot_addr(k, tail);
    wq_raddr = slot_addr(k, cur_head);
  end

  // request decode for the operation step and the handover step
  always_comb begin
    ent_we  = 1'b0;
    wq_we   = 1'b0;
    op_hand = 1'b0;
    w_owned = cur_owned;
    w_owner = cur_owner;
    w_count = cur_count;
    w_head  = cur_head;
    op_res  = '{outcome: OC_NOTOWNER, must_block: 1'b0, wake_valid: 1'b0,
                wake_task: '0};
    if (state == S_OP) begin
      if (cur_req.mode == MODE_LOCK) begin
        ent_we = 1'b1;
        if (!cur_owned) begin
          w_owned        = 1'b1;
          w_owner        = cur_req.task_id;
          op_res.outcome = OC_GRANTED;
        end else if (cur_count < CW'(QUEUE_DEPTH)) begin
          wq_we             = 1'b1;
          w_count           = cur_count + CW'(1);
          op_res.outcome    = OC_BLOCKED;
          op_res.must_block = 1'b1;
        end else begin
          op_res.outcome = OC_QFULL;
        end
      end else begin
        if (!cur_owned || cur_owner != cur_req.task_id) begin
          ent_we = 1'b1;
        end else if (cur_count == '0) begin
          ent_we         = 1'b1;
          w_owned        = 1'b0;
          op_res.outcome = OC_FREED;
        end else begin
          op_hand = 1'b1;
        end
      end
    end else if (state == S_HAND) begin
      ent_we            = 1'b1;
      w_owner           = wq_rdata;
      w_count           = cur_count - CW'(1);
      w_head            = head_inc;
      op_res.outcome    = OC_HANDED;
      op_res.wake_valid = 1'b1;
      op_res.wake_task  = wq_rdata;
    end
  end

  // entry table write and registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_id[k]    <= cur_req.lock_id;
      ent_owned[k] <= w_owned;
      ent_owner[k] <= w_owner;
      ent_count[k] <= w_count;
      ent_head[k]  <= w_head;
    end
    rd_id    <= ent_id[ent_raddr];
    rd_owned <= ent_owned[ent_raddr];
    rd_owner <= ent_owner[ent_raddr];
    rd_count <= ent_count[ent_raddr];
    rd_head  <= ent_head[ent_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      cmp_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_req  <= req;
            scan_idx <= '0;
            cmp_pend <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            k         <= cmp_idx;
            cur_owned <= rd_owned;
            cur_owner <= rd_owner;
            cur_count <= rd_count;
            cur_head  <= rd_head;
            cmp_pend  <= 1'b0;
            state     <= S_OP;
          end else if (scan_idx < used) begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_idx[IW-1:0];
            scan_idx <= scan_idx + UW'(1);
          end else begin
            cmp_pend <= 1'b0;
            if (!cmp_pend) begin
              if (used == UW'(NUM_LOCKS)) begin
                result <= '{outcome: OC_TFULL, must_block: 1'b0, wake_valid: 1'b0,
                            wake_task: '0};
                state  <= S_RESP;
              end else begin
                // new entry, created free with an empty queue
                k         <= used[IW-1:0];
                cur_owned <= 1'b0;
                cur_owner <= '0;
                cur_count <= '0;
                cur_head  <= '0;
                used      <= used + UW'(1);
                state     <= S_OP;
              end
            end
          end
        end
        S_OP: begin
          if (op_hand) begin
            state <= S_HAND;
          end else begin
            result <= op_res;
            state  <= S_RESP;
          end
        end
        S_HAND: begin
          result <= op_res;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mlm_wait_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_wait_mem (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (cur_req.task_id),
    .raddr (wq_raddr),
    .rdata (wq_rdata)
  );

endmodule

`default_nettype wire

FILE: sim/lock_grant_checker.sv
`timescale 1ns / 100ps
// lock_grant_checker: watches both stream channels of the lock manager, keeps its own
// lock table to predict each result beat, and compares field by field. Needs mlm_pkg.
module lock_grant_checker import mlm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,   // lock_id[15:0], task_id[23:16]
  input  wire logic        s_tuser,   // mode
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,   // outcome[2:0], must_block[3], wake_valid[4],
                                      // wake_task[12:5], zero[15:13]
  output int               pending,
  output int               errors
);

  localparam int NL        = NUM_LOCKS_DEF;
  localparam int QD        = QUEUE_DEPTH_DEF;
  localparam int MAX_LINES = 60;

  // shadow lock table
  int unsigned       used_cnt;
  logic [ID_W-1:0]   tbl_id      [NL];
  logic              tbl_held    [NL];
  logic [TASK_W-1:0] tbl_owner   [NL];
  int unsigned       tbl_waiting [NL];
  logic [TASK_W-1:0] waitq       [NL][QD];

  res_t expected_results[$];
  int   err_cnt;
  int   beat_no;

  task automatic report_mismatch(string what, int got, int want);
    if (err_cnt < MAX_LINES)
      $display("%0t lock checker: result beat %0d, %s: got 0x%0h, expected 0x%0h",
               $time, beat_no, what, got, want);
    err_cnt++;
  endtask

  // apply one request to the shadow table and return the result it causes
  function automatic res_t predict_lock_request(req_t rq);
    res_t        r;
    int          hit;
    int          i;
    int unsigned n;
    r   = '0;
    hit = -1;
    for (i = 0; i < int'(used_cnt); i++)
      if (hit < 0 && tbl_id[i] == rq.lock_id) hit = i;
    // first use claims the next entry, for unlock as well
    if (hit < 0 && used_cnt < NL) begin
      hit = int'(used_cnt);
      used_cnt++;
      tbl_id[hit]      = rq.lock_id;
      tbl_held[hit]    = 1'b0;
      tbl_owner[hit]   = '0;
      tbl_waiting[hit] = 0;
    end
    if (hit < 0) begin
      r.outcome = OC_TFULL;
    end else begin
      n = tbl_waiting[hit];
      if (rq.mode == MODE_LOCK) begin
        if (!tbl_held[hit]) begin
          tbl_held[hit]  = 1'b1;
          tbl_owner[hit] = rq.task_id;
          r.outcome      = OC_GRANTED;
        end else if (n < QD) begin
          // owner locking again queues behind itself too
          waitq[hit][n]    = rq.task_id;
          tbl_waiting[hit] = n + 1;
          r.outcome        = OC_BLOCKED;
          r.must_block     = 1'b1;
        end else begin
          r.outcome = OC_QFULL;
        end
      end else if (!tbl_held[hit] || tbl_owner[hit] != rq.task_id) begin
        r.outcome = OC_NOTOWNER;
      end else if (n == 0) begin
        tbl_held[hit] = 1'b0;
        r.outcome     = OC_FREED;
      end else begin
        // oldest waiter takes over, rest of the queue moves up
        r.wake_task    = waitq[hit][0];
        r.wake_valid   = 1'b1;
        r.outcome      = OC_HANDED;
        tbl_owner[hit] = waitq[hit][0];
        for (i = 0; i + 1 < int'(n); i++)
          waitq[hit][i] = waitq[hit][i + 1];
        tbl_waiting[hit] = n - 1;
      end
    end
    return r;
  endfunction

  // result beats are checked before the same edge's request is predicted
  always @(posedge clk) begin
    res_t want;
    req_t rq;
    if (rst) begin
      used_cnt = 0;
      expected_results.delete();
      err_cnt = 0;
      beat_no = 0;
      pending <= 0;
      errors  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("beat with no request waiting", int'(m_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[2:0] != want.outcome)
            report_mismatch("outcome", int'(m_tdata[2:0]), int'(want.outcome));
          if (m_tdata[3] != want.must_block)
            report_mismatch("must_block", int'(m_tdata[3]), int'(want.must_block));
          if (m_tdata[4] != want.wake_valid)
            report_mismatch("wake_valid", int'(m_tdata[4]), int'(want.wake_valid));
          if (m_tdata[12:5] != want.wake_task)
            report_mismatch("wake_task", int'(m_tdata[12:5]), int'(want.wake_task));
          if (m_tdata[15:13] != 3'b000)
            report_mismatch("padding", int'(m_tdata[15:13]), 0);
        end
        beat_no++;
      end
      if (s_tvalid && s_tready) begin
        rq.mode    = s_tuser;
        rq.lock_id = s_tdata[15:0];
        rq.task_id = s_tdata[23:16];
        expected_results.push_back(predict_lock_request(rq));
      end
      pending <= expected_results.size();
      errors  <= err_cnt;
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset and request stimulus for mutex_lock_manager_top, plus the verdict.
// Depends on mlm_pkg, the lock manager RTL and lock_grant_checker.
module tb_top;
  import mlm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // lock_id[15:0], task_id[23:16]
  logic        s_tuser  = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // outcome, must_block, wake_valid, wake_task, zero pad
  logic        calm     = 1'b0;
  int          pending;
  int          errors;
  int          ready_hold   = 0;
  int          quiet_cycles = 0;
  logic [15:0] id_pool [16];
  logic [7:0]  task_pool [3];

  always #10 clk = ~clk;

  mutex_lock_manager_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lock_grant_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pending  (pending),
    .errors   (errors)
  );

  // result side: ready runs alternating with stall bursts
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end else begin
      m_tready   <= 1'b0;
      ready_hold <= $urandom_range(0, 13);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** mutex_lock_manager_top: FAILED **");
      $finish;
    end
  end

  // present one request and hold it until the beat is taken
  task automatic issue_request(logic mode, logic [15:0] lock_id, logic [7:0] task_id);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {task_id, lock_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          p;
    int          i;
    int          unlock_pct;
    logic        mode;
    logic [15:0] lock_id;
    logic [7:0]  task_id;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (i = 2; i < 16; i++) id_pool[i] = 16'($urandom);
    task_pool[0] = 8'h01;
    task_pool[1] = 8'h02;
    task_pool[2] = 8'h03;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-ones lock: grant, self-lock blocks, foreign unlock, handover to self, free
    issue_request(MODE_LOCK,   16'hFFFF, 8'hFF);
    issue_request(MODE_LOCK,   16'hFFFF, 8'hFF);
    issue_request(MODE_UNLOCK, 16'hFFFF, 8'h00);
    issue_request(MODE_UNLOCK, 16'hFFFF, 8'hFF);
    issue_request(MODE_UNLOCK, 16'hFFFF, 8'hFF);
    // unlock of an unknown lock creates a free entry, then it is granted
    issue_request(MODE_UNLOCK, 16'h0000, 8'h00);
    issue_request(MODE_LOCK,   16'h0000, 8'h00);
    // fill the wait queue, one more is refused as full, then hand over to the oldest
    for (i = 1; i <= 8; i++) issue_request(MODE_LOCK, 16'h0000, 8'(i));
    issue_request(MODE_LOCK,   16'h0000, 8'h09);
    issue_request(MODE_UNLOCK, 16'h0000, 8'h00);
    drain_results();

    // random phases; mostly pooled locks and tasks so unlocks hit owners,
    // a few fresh ids that end up hitting a full table
    for (p = 0; p < PHASES; p++) begin
      calm <= (p == PHASES - 1);
      case ($urandom_range(0, 2))
        0:       unlock_pct = 30;
        1:       unlock_pct = 50;
        default: unlock_pct = 75;
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p != PHASES - 1 && $urandom_range(0, 3) == 0)
          idle_gap($urandom_range(1, 14));
        if ($urandom_range(0, 99) < 3)
          lock_id = 16'($urandom);
        else
          lock_id = id_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 9) == 0)
          task_id = 8'($urandom);
        else
          task_id = task_pool[$urandom_range(0, 2)];
        mode = ($urandom_range(0, 99) < unlock_pct) ? MODE_UNLOCK : MODE_LOCK;
        issue_request(mode, lock_id, task_id);
      end
      if (p % 2 == 1) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("** mutex_lock_manager_top: PASSED **");
    else
      $display("** mutex_lock_manager_top: FAILED **");
    $finish;
  end

endmodule

FILE: mutex_lock_manager_top.f
sv/mlm_pkg.sv
sv/mlm_wait_mem.sv
sv/mlm_core.sv
sv/mutex_lock_manager_top.sv
sim/lock_grant_checker.sv
sim/tb_top.sv
